// ===== design/fqp_pkg.sv =====
// Shared request, status and command types for the FIFO queue with peek.
package fqp_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FRONT = 2'd2,
    REQ_PEEK  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned IndexW = 8;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    req_e              kind;
    logic [DataW-1:0]  value;
    logic [IndexW-1:0] index;
  } cmd_t;

endpackage

// ===== design/fqp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fqp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fqp_front.sv =====
// Front end: accepts request beats, classifies them and buffers them in a two-entry queue.
module fqp_front
  import fqp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [DataW-1:0]  push_value_i,
  input  logic [IndexW-1:0] peek_index_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  cmd_t       slot_q [2];
  cmd_t       slot_d [2];
  logic [1:0] fill_q, fill_d;
  cmd_t       new_cmd;
  logic       push, pop;

  // A peek at position zero or one always lands on the front item, so it is
  // handed to the back end as a plain front read.
  always_comb begin
    new_cmd.kind  = req_e'(req_type_i);
    new_cmd.value = push_value_i;
    new_cmd.index = peek_index_i;
    if (new_cmd.kind == REQ_PEEK && peek_index_i <= IndexW'(1)) begin
      new_cmd.kind = REQ_FRONT;
    end
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[0];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    fill_d    = fill_q;
    if (push && !pop) begin
      if (fill_q == 2'd0) begin
        slot_d[0] = new_cmd;
      end else begin
        slot_d[1] = new_cmd;
      end
      fill_d = fill_q + 2'd1;
    end else if (!push && pop) begin
      slot_d[0] = slot_q[1];
      fill_d    = fill_q - 2'd1;
    end else if (push && pop) begin
      if (fill_q == 2'd1) begin
        slot_d[0] = new_cmd;
      end else begin
        slot_d[0] = slot_q[1];
        slot_d[1] = new_cmd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

endmodule

// ===== design/fqp_back.sv =====
// Back end: owns the ring store, head and count, reduces peek indices and holds the result.
module fqp_back
  import fqp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DataW-1:0]  read_value_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] item_count_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned XW = ((CW > IndexW) ? CW : IndexW) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [IndexW-1:0] num_q, num_d;
  logic [2:0]        step_q, step_d;
  logic [DataW-1:0]  rd_q, rd_d;
  status_e           status_q, status_d;

  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata, rdata;
  logic [VALUE_WIDTH+DataW-1:0] push_ext, read_ext;
  logic [CW+CountW-1:0]   count_ext;
  logic [CW:0]            trial, diff;

  // Slot that lies a given number of places behind a base slot, for offsets
  // below the depth.
  function automatic logic [AW-1:0] slot_after(logic [AW-1:0] base, logic [XW-1:0] off);
    logic [XW-1:0] sum;
    sum = XW'(base) + off;
    if (sum >= XW'(QUEUE_DEPTH)) begin
      sum = sum - XW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  fqp_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign push_ext  = {{VALUE_WIDTH{1'b0}}, cmd_i.value};
  assign wdata     = push_ext[VALUE_WIDTH-1:0];
  assign read_ext  = {{DataW{1'b0}}, rdata};
  assign count_ext = {{CountW{1'b0}}, count_q};

  // One restoring step of the index remainder per cycle.
  assign trial = {rem_q, num_q[IndexW-1]};
  assign diff  = trial - {1'b0, count_q};

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    rem_d    = rem_q;
    num_d    = num_q;
    step_d   = step_q;
    rd_d     = rd_q;
    status_d = status_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = slot_after(head_q, XW'(count_q));
    raddr    = head_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          rd_d     = '0;
          status_d = STATUS_OK;
          state_d  = S_READ;
          if (cmd_i.kind == REQ_PUSH) begin
            state_d = S_RESP;
            if (count_q == CW'(QUEUE_DEPTH)) begin
              status_d = STATUS_FULL;
            end else begin
              we      = 1'b1;
              count_d = count_q + CW'(1);
            end
          end else if (count_q == '0) begin
            status_d = STATUS_EMPTY;
            state_d  = S_RESP;
          end else begin
            case (cmd_i.kind)
              REQ_POP: begin
                re      = 1'b1;
                head_d  = slot_after(head_q, XW'(1));
                count_d = count_q - CW'(1);
              end
              REQ_PEEK: begin
                // The front end only passes peeks at position two or more.
                if (count_q == CW'(1)) begin
                  re = 1'b1;
                end else if (XW'(cmd_i.index) > XW'(count_q)) begin
                  num_d   = cmd_i.index;
                  rem_d   = '0;
                  step_d  = '0;
                  state_d = S_DIV;
                end else begin
                  re    = 1'b1;
                  raddr = slot_after(head_q, XW'(cmd_i.index) - XW'(1));
                end
              end
              default: begin
                re = 1'b1;
              end
            endcase
          end
        end
      end
      S_DIV: begin
        rem_d  = diff[CW] ? trial[CW-1:0] : diff[CW-1:0];
        num_d  = {num_q[IndexW-2:0], 1'b0};
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        re      = 1'b1;
        raddr   = (rem_q <= CW'(1)) ? head_q
                                    : slot_after(head_q, XW'(rem_q) - XW'(1));
        state_d = S_READ;
      end
      S_READ: begin
        rd_d    = read_ext[DataW-1:0];
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    num_q    <= num_d;
    step_q   <= step_d;
    rd_q     <= rd_d;
    status_q <= status_d;
  end

  assign cmd_ready_o  = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_RESP);
  assign read_value_o = rd_q;
  assign status_o     = status_q;
  assign item_count_o = count_ext[CountW-1:0];

endmodule

// ===== design/fifo_queue_with_peek_unit.sv =====
// Top level of the FIFO queue with peek: front request buffer and back execution engine.
//
// A first-in first-out queue of QUEUE_DEPTH values held in a ring store. Every
// request beat (push, pop, read front, or peek at a 1-based position from the
// front) yields exactly one result beat carrying the value read, a status (ok,
// empty, or full with the push dropped) and the number of items held after the
// request. A peek index larger than the item count is reduced modulo the count;
// indices zero and one both give the front, and the count itself gives the rear.
// Requests pass through a two-entry buffer in the front end, so up to two further
// beats are taken while the back end is busy or its result is still waiting to be
// taken. The back end carries out one request at a time: a push, or any request
// that ends in an empty or full status, goes straight to presenting its result;
// a pop, a front read or a peek that needs no reduction passes through a read
// state first, as the ring store has a registered read port; a peek whose index
// exceeds the count first has its remainder formed one index bit per cycle and
// then looks up and reads the store. Values in the store are undefined until
// pushed, and nothing else needs clearing after reset.
module fifo_queue_with_peek_unit
  import fqp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [DataW-1:0]  push_value_i,
  input  logic [IndexW-1:0] peek_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DataW-1:0]  read_value_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] item_count_o
);

  // Classified requests travelling from the front buffer to the back end.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // The front end decodes each beat and turns low peek indices into front reads.
  fqp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .push_value_i(push_value_i),
    .peek_index_i(peek_index_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // The back end holds the head slot, the item count and the ring store, and
  // keeps the finished result in its output register until it is taken.
  fqp_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .item_count_o(item_count_o)
  );

endmodule

// ===== design/fqp_checker.sv =====
// Port-level checks on the FIFO queue with peek, bound to the top level.
module fqp_checker
  import fqp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DataW-1:0]  read_value_o,
  input logic [1:0]        status_o,
  input logic [CountW-1:0] item_count_o
);

  localparam logic [CountW-1:0] FullCount = CountW'(QUEUE_DEPTH);

  // A result that is not taken keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(status_o) && $stable(item_count_o))
    else $error("result beat changed while stalled");

  // An empty status only arises with no items held and carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EMPTY |-> item_count_o == '0 && read_value_o == '0)
    else $error("empty status with items held or non-zero value");

  // A dropped push reports a full queue and a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |-> item_count_o == FullCount
      && read_value_o == '0)
    else $error("full status with wrong count or non-zero value");

endmodule

bind fifo_queue_with_peek_unit fqp_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_fqp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .read_value_o(read_value_o),
  .status_o    (status_o),
  .item_count_o(item_count_o)
);
